// ===== src/ssco_pkg.sv =====
// ----------------------------------------------------------------------------
// ssco_pkg: shared types and constants of the green split optimizer
//
// Field widths, register map, the configuration bundle and the ratio form
// used to compare capacities exactly.
// ----------------------------------------------------------------------------
package ssco_pkg;

  localparam int unsigned FLOW_BITS = 10;
  localparam int unsigned TIME_BITS = 8;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned INT_BITS  = 8;
  localparam int unsigned CAP_BITS  = INT_BITS + FRAC_BITS;
  localparam int unsigned SAT_BITS  = 10;
  localparam int unsigned YEL_BITS  = 4;

  localparam int unsigned NUM_W  = SAT_BITS + TIME_BITS;
  localparam int unsigned DEN_W  = FLOW_BITS + TIME_BITS;
  localparam int unsigned PROD_W = FLOW_BITS + TIME_BITS;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [TIME_BITS-1:0] CYCLE_RST   = TIME_BITS'(90);
  localparam logic [YEL_BITS-1:0]  YELLOW_RST  = YEL_BITS'(4);
  localparam logic [SAT_BITS-1:0]  SAT_RST     = SAT_BITS'(120);
  localparam logic [TIME_BITS-1:0] GMIN_RST    = TIME_BITS'(4);
  localparam logic [TIME_BITS-1:0] GMAX_RST    = TIME_BITS'(78);
  localparam logic [TIME_BITS-1:0] BALANCE_RST = TIME_BITS'(41);

  typedef enum logic [2:0] {
    REG_CYCLE   = 3'd0,
    REG_YELLOW  = 3'd1,
    REG_SAT     = 3'd2,
    REG_GMIN    = 3'd3,
    REG_GMAX    = 3'd4,
    REG_BALANCE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] cycle_length;
    logic [YEL_BITS-1:0]  yellow_time;
    logic [SAT_BITS-1:0]  saturation_flow;
    logic [TIME_BITS-1:0] green_min;
    logic [TIME_BITS-1:0] green_max;
    logic [TIME_BITS-1:0] balanced_green;
  } cfg_t;

  // Capacity saturation_flow * t / (f * cycle), or unbounded.
  typedef struct packed {
    logic                 unb;
    logic [TIME_BITS-1:0] t;
    logic [FLOW_BITS-1:0] f;
  } ratio_t;

endpackage

// ===== src/signal_split_capacity_optimizer_core.sv =====
// ----------------------------------------------------------------------------
// signal_split_capacity_optimizer_core: green split optimizer top level
//
// Searches vertical green times for the largest minimum approach capacity.
// ----------------------------------------------------------------------------
// One word of four flow counts is taken while the block is idle, and one
// result word follows. The search visits each green time in the range
// green_min..green_max through the states S_MIN and S_BEST on the shared
// exact comparator, then the bit-serial divider converts first the best and
// then the balanced capacity. A finished word waits in the output register
// while the next item is already taken.
module signal_split_capacity_optimizer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssco_pkg::ADDR_W-1:0]     paddr,
  input  logic [ssco_pkg::DATA_W-1:0]     pwdata,
  output logic [ssco_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ssco_pkg::FLOW_BITS-1:0]  flow_north_i,
  input  logic [ssco_pkg::FLOW_BITS-1:0]  flow_east_i,
  input  logic [ssco_pkg::FLOW_BITS-1:0]  flow_south_i,
  input  logic [ssco_pkg::FLOW_BITS-1:0]  flow_west_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ssco_pkg::TIME_BITS-1:0]  best_vertical_green_o,
  output logic [ssco_pkg::TIME_BITS-1:0]  best_horizontal_green_o,
  output logic [ssco_pkg::CAP_BITS-1:0]   best_capacity_o,
  output logic [ssco_pkg::CAP_BITS-1:0]   balanced_capacity_o,
  output logic                            best_unbounded_o,
  output logic                            balanced_unbounded_o
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_BAL       = 9'b000000010,
    S_MIN       = 9'b000000100,
    S_BEST      = 9'b000001000,
    S_DIVB_GO   = 9'b000010000,
    S_DIVB_WAIT = 9'b000100000,
    S_DIVA_GO   = 9'b001000000,
    S_DIVA_WAIT = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

  function automatic logic [ssco_pkg::TIME_BITS-1:0] horiz_green(
    input logic [ssco_pkg::TIME_BITS-1:0] g,
    input logic [ssco_pkg::TIME_BITS-1:0] c,
    input logic [ssco_pkg::YEL_BITS-1:0]  y
  );
    logic [ssco_pkg::TIME_BITS:0] used;
    used = {1'b0, g} + ((ssco_pkg::TIME_BITS + 1)'(y) << 1);
    if ({1'b0, c} > used) begin
      return ssco_pkg::TIME_BITS'({1'b0, c} - used);
    end
    return '0;
  endfunction

  ssco_pkg::cfg_t                 cfg;
  state_e                         state_q, state_d;
  logic                           out_valid_q;

  logic [ssco_pkg::FLOW_BITS-1:0] fv_q, fh_q;
  logic [ssco_pkg::TIME_BITS-1:0] g_q, best_g_q;
  ssco_pkg::ratio_t               best_q, bal_q, cand_q;
  logic [ssco_pkg::CAP_BITS-1:0]  cap_best_q;
  logic [ssco_pkg::CAP_BITS-1:0]  cap_bal_q;

  logic [ssco_pkg::TIME_BITS-1:0] bvg_q, bhg_q;
  logic [ssco_pkg::CAP_BITS-1:0]  bcap_q, acap_q;
  logic                           bunb_q, aunb_q;

  logic                           accept;
  logic                           load_out;
  logic                           empty_range;
  logic                           sat_nz;
  logic [ssco_pkg::TIME_BITS-1:0] sel_g;
  logic [ssco_pkg::TIME_BITS-1:0] cycle_eff;
  ssco_pkg::ratio_t               v_r, h_r, cmp_a, cmp_b, min_r, div_r;
  logic                           gt;
  logic                           div_start, div_done;
  logic [ssco_pkg::CAP_BITS-1:0]  div_quot;

  ssco_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign load_out    = state_q == S_DONE && (!out_valid_q || !out_stall_i);
  assign empty_range = cfg.green_min > cfg.green_max;
  assign sat_nz      = cfg.saturation_flow != '0;
  assign cycle_eff   = (cfg.cycle_length == '0) ? ssco_pkg::TIME_BITS'(1)
                                                : cfg.cycle_length;

  assign sel_g   = (state_q == S_BAL) ? cfg.balanced_green : g_q;
  assign v_r.unb = fv_q == '0;
  assign v_r.t   = sel_g;
  assign v_r.f   = fv_q;
  assign h_r.unb = fh_q == '0;
  assign h_r.t   = horiz_green(sel_g, cfg.cycle_length, cfg.yellow_time);
  assign h_r.f   = fh_q;

  assign cmp_a = (state_q == S_BEST) ? cand_q : v_r;
  assign cmp_b = (state_q == S_BEST) ? best_q : h_r;
  assign min_r = gt ? h_r : v_r;

  ssco_ratio_cmp u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .sat_nz_i (sat_nz),
    .gt_o     (gt)
  );

  assign div_start = state_q == S_DIVB_GO || state_q == S_DIVA_GO;
  assign div_r     = (state_q == S_DIVA_GO) ? bal_q : best_q;

  ssco_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sat_i   (cfg.saturation_flow),
    .cycle_i (cycle_eff),
    .t_i     (div_r.t),
    .f_i     (div_r.f),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (accept) state_d = S_BAL;
      S_BAL:       state_d = empty_range ? S_DIVB_GO : S_MIN;
      S_MIN:       state_d = S_BEST;
      S_BEST:      state_d = (g_q == cfg.green_max) ? S_DIVB_GO : S_MIN;
      S_DIVB_GO:   state_d = S_DIVB_WAIT;
      S_DIVB_WAIT: if (div_done) state_d = S_DIVA_GO;
      S_DIVA_GO:   state_d = S_DIVA_WAIT;
      S_DIVA_WAIT: if (div_done) state_d = S_DONE;
      S_DONE:      if (load_out) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fv_q       <= (flow_north_i > flow_south_i) ? flow_north_i : flow_south_i;
      fh_q       <= (flow_east_i > flow_west_i) ? flow_east_i : flow_west_i;
      best_q.unb <= 1'b0;
      best_q.t   <= '0;
      best_q.f   <= ssco_pkg::FLOW_BITS'(1);
      best_g_q   <= '0;
    end
    if (state_q == S_BAL) begin
      bal_q <= min_r;
      g_q   <= cfg.green_min;
    end
    if (state_q == S_MIN) begin
      cand_q <= min_r;
    end
    if (state_q == S_BEST) begin
      if (gt) begin
        best_q   <= cand_q;
        best_g_q <= g_q;
      end
      g_q <= g_q + ssco_pkg::TIME_BITS'(1);
    end
    if (state_q == S_DIVB_WAIT && div_done) begin
      cap_best_q <= best_q.unb ? '1 : div_quot;
    end
    if (state_q == S_DIVA_WAIT && div_done) begin
      cap_bal_q <= bal_q.unb ? '1 : div_quot;
    end
    if (load_out) begin
      bvg_q  <= best_g_q;
      bhg_q  <= horiz_green(best_g_q, cfg.cycle_length, cfg.yellow_time);
      bcap_q <= cap_best_q;
      acap_q <= cap_bal_q;
      bunb_q <= best_q.unb;
      aunb_q <= bal_q.unb;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign best_vertical_green_o   = bvg_q;
  assign best_horizontal_green_o = bhg_q;
  assign best_capacity_o         = bcap_q;
  assign balanced_capacity_o     = acap_q;
  assign best_unbounded_o        = bunb_q;
  assign balanced_unbounded_o    = aunb_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word raised outside the completion state");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVB_WAIT || state_q == S_DIVA_WAIT))
    else $error("divider finished while nobody was waiting for it");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVB_GO |->
      (best_g_q == '0 ||
       (best_g_q >= cfg.green_min && best_g_q <= cfg.green_max)))
    else $error("chosen green lies outside the searched range");

  a_unb_only_no_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && best_q.unb) |-> (fv_q == '0 && fh_q == '0))
    else $error("unbounded best capacity with a nonzero flow");

endmodule

// ===== src/ssco_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ssco_cfg_regs: configuration register file
//
// APB-style slave holding the six timing and flow registers.
// ----------------------------------------------------------------------------
module ssco_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssco_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssco_pkg::DATA_W-1:0]  pwdata,
  output logic [ssco_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ssco_pkg::cfg_t               cfg_o
);

  ssco_pkg::cfg_t     cfg_q;
  ssco_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = ssco_pkg::reg_idx_e'(paddr[ssco_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycle_length    <= ssco_pkg::CYCLE_RST;
      cfg_q.yellow_time     <= ssco_pkg::YELLOW_RST;
      cfg_q.saturation_flow <= ssco_pkg::SAT_RST;
      cfg_q.green_min       <= ssco_pkg::GMIN_RST;
      cfg_q.green_max       <= ssco_pkg::GMAX_RST;
      cfg_q.balanced_green  <= ssco_pkg::BALANCE_RST;
    end else if (wr_en) begin
      unique case (idx)
        ssco_pkg::REG_CYCLE: begin
          cfg_q.cycle_length <= pwdata[ssco_pkg::TIME_BITS-1:0];
        end
        ssco_pkg::REG_YELLOW: begin
          cfg_q.yellow_time <= pwdata[ssco_pkg::YEL_BITS-1:0];
        end
        ssco_pkg::REG_SAT: begin
          cfg_q.saturation_flow <= pwdata[ssco_pkg::SAT_BITS-1:0];
        end
        ssco_pkg::REG_GMIN: begin
          cfg_q.green_min <= pwdata[ssco_pkg::TIME_BITS-1:0];
        end
        ssco_pkg::REG_GMAX: begin
          cfg_q.green_max <= pwdata[ssco_pkg::TIME_BITS-1:0];
        end
        ssco_pkg::REG_BALANCE: begin
          cfg_q.balanced_green <= pwdata[ssco_pkg::TIME_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ssco_pkg::REG_CYCLE:   prdata = ssco_pkg::DATA_W'(cfg_q.cycle_length);
      ssco_pkg::REG_YELLOW:  prdata = ssco_pkg::DATA_W'(cfg_q.yellow_time);
      ssco_pkg::REG_SAT:     prdata = ssco_pkg::DATA_W'(cfg_q.saturation_flow);
      ssco_pkg::REG_GMIN:    prdata = ssco_pkg::DATA_W'(cfg_q.green_min);
      ssco_pkg::REG_GMAX:    prdata = ssco_pkg::DATA_W'(cfg_q.green_max);
      ssco_pkg::REG_BALANCE: prdata = ssco_pkg::DATA_W'(cfg_q.balanced_green);
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== src/ssco_ratio_cmp.sv =====
// ----------------------------------------------------------------------------
// ssco_ratio_cmp: shared exact capacity comparator
//
// Tells whether capacity a is strictly greater than capacity b by cross
// multiplication; saturation flow and cycle length cancel on both sides.
// ----------------------------------------------------------------------------
module ssco_ratio_cmp (
  input  ssco_pkg::ratio_t a_i,
  input  ssco_pkg::ratio_t b_i,
  input  logic             sat_nz_i,
  output logic             gt_o
);

  logic [ssco_pkg::PROD_W-1:0] lhs;
  logic [ssco_pkg::PROD_W-1:0] rhs;

  assign lhs = ssco_pkg::PROD_W'(a_i.t) * ssco_pkg::PROD_W'(b_i.f);
  assign rhs = ssco_pkg::PROD_W'(b_i.t) * ssco_pkg::PROD_W'(a_i.f);

  always_comb begin
    if (b_i.unb) begin
      gt_o = 1'b0;
    end else if (a_i.unb) begin
      gt_o = 1'b1;
    end else begin
      gt_o = sat_nz_i && (lhs > rhs);
    end
  end

endmodule

// ===== src/ssco_div.sv =====
// ----------------------------------------------------------------------------
// ssco_div: iterative capacity divider
//
// Forms saturation_flow * t and f * cycle, then produces the truncated
// unsigned fixed point quotient one bit per cycle, saturating at all ones.
// ----------------------------------------------------------------------------
module ssco_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ssco_pkg::SAT_BITS-1:0]   sat_i,
  input  logic [ssco_pkg::TIME_BITS-1:0]  cycle_i,
  input  logic [ssco_pkg::TIME_BITS-1:0]  t_i,
  input  logic [ssco_pkg::FLOW_BITS-1:0]  f_i,
  output logic                            done_o,
  output logic [ssco_pkg::CAP_BITS-1:0]   quot_o
);

  localparam int unsigned CNT_W = $clog2(ssco_pkg::CAP_BITS);
  localparam int unsigned OVF_W = ssco_pkg::DEN_W + ssco_pkg::INT_BITS;

  typedef enum logic [2:0] {
    DIV_IDLE  = 3'b001,
    DIV_CHECK = 3'b010,
    DIV_RUN   = 3'b100
  } div_state_e;

  div_state_e                    state_q, state_d;
  logic [CNT_W-1:0]              cnt_q;
  logic                          done_q;
  logic [ssco_pkg::NUM_W-1:0]    num_q;
  logic [ssco_pkg::DEN_W-1:0]    den_q;
  logic [ssco_pkg::DEN_W-1:0]    rem_q;
  logic [ssco_pkg::CAP_BITS-1:0] sh_q;
  logic [ssco_pkg::CAP_BITS-1:0] quot_q;

  logic                          ovf;
  logic [ssco_pkg::DEN_W:0]      trial;
  logic                          ge;
  logic [ssco_pkg::DEN_W-1:0]    rem_d;
  logic                          last;

  assign ovf   = OVF_W'(num_q) >= {den_q, {ssco_pkg::INT_BITS{1'b0}}};
  assign trial = {rem_q, sh_q[ssco_pkg::CAP_BITS-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? ssco_pkg::DEN_W'(trial - {1'b0, den_q})
                    : ssco_pkg::DEN_W'(trial);
  assign last  = cnt_q == CNT_W'(ssco_pkg::CAP_BITS - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE:  if (start_i) state_d = DIV_CHECK;
      DIV_CHECK: state_d = ovf ? DIV_IDLE : DIV_RUN;
      DIV_RUN:   if (last) state_d = DIV_IDLE;
      default:   state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DIV_CHECK && ovf) || (state_q == DIV_RUN && last);
      if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      num_q <= ssco_pkg::NUM_W'(sat_i) * ssco_pkg::NUM_W'(t_i);
      den_q <= ssco_pkg::DEN_W'(f_i) * ssco_pkg::DEN_W'(cycle_i);
    end
    if (state_q == DIV_CHECK) begin
      rem_q <= ssco_pkg::DEN_W'(num_q >> ssco_pkg::INT_BITS);
      sh_q  <= {num_q[ssco_pkg::INT_BITS-1:0], {ssco_pkg::FRAC_BITS{1'b0}}};
      if (ovf) begin
        quot_q <= '1;
      end
    end
    if (state_q == DIV_RUN) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[ssco_pkg::CAP_BITS-2:0], ge};
      if (last) begin
        quot_q <= {sh_q[ssco_pkg::CAP_BITS-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DIV_RUN |-> rem_q < den_q)
    else $error("partial remainder not below divisor");

endmodule
